### rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DQ_DEPTH  = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_kind_t;

    // control part of a classified item, handed from front to back
    typedef struct packed {
        op_kind_t kind;
        status_t  status;
        logic     is_empty;
        logic     is_full;
    } op_ctrl_t;

endpackage

### rtl/core/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front
// Accepts commands, keeps the end pointers and classifies each item into a
// slot write, a slot read or a plain status result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_front
    import dq_pkg::*;
#(
    parameter int DEPTH  = DQ_DEPTH,
    parameter int PTR_W  = $clog2(DEPTH + 1),
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] data,
    output logic                     push,
    output op_ctrl_t                 ctrl,
    output logic [ADDR_W-1:0]        addr,
    output logic signed [DATA_W-1:0] wdata
);

    localparam logic [PTR_W-1:0] FULL_PTR = PTR_W'(DEPTH);
    localparam logic [PTR_W-1:0] ONE_PTR  = PTR_W'(1);

    // rear holds the last item's index + 1 and front the first item's index, so rear zero means index -1
    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] rear_reg,  rear_next;
    logic [PTR_W-1:0] front_dec, rear_dec;
    logic             empty;

    assign front_dec = front_reg - ONE_PTR;
    assign rear_dec  = rear_reg - ONE_PTR;
    assign empty     = (front_reg == rear_reg);

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        ctrl.kind   = OP_NONE;
        ctrl.status = ST_DONE;
        addr        = rear_reg[ADDR_W-1:0];
        case (cmd_t'(cmd))
            CMD_PUSH_BACK:
            begin
                if (rear_reg == FULL_PTR)
                begin
                    ctrl.status = ST_NO_ROOM;
                end
                else
                begin
                    ctrl.kind = OP_WRITE;
                    addr      = rear_reg[ADDR_W-1:0];
                    rear_next = rear_reg + ONE_PTR;
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (front_reg == '0)
                begin
                    ctrl.status = ST_NO_ROOM;
                end
                else
                begin
                    ctrl.kind  = OP_WRITE;
                    addr       = front_dec[ADDR_W-1:0];
                    front_next = front_dec;
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    ctrl.status = ST_EMPTY;
                end
                else
                begin
                    ctrl.kind  = OP_READ;
                    addr       = front_reg[ADDR_W-1:0];
                    front_next = front_reg + ONE_PTR;
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    ctrl.status = ST_EMPTY;
                end
                else
                begin
                    ctrl.kind = OP_READ;
                    addr      = rear_dec[ADDR_W-1:0];
                    rear_next = rear_dec;
                end
            end
            default:
            begin
                ctrl.status = ST_DONE;
            end
        endcase
        ctrl.is_empty = (front_next == rear_next);
        ctrl.is_full  = (rear_next == FULL_PTR);
    end

    assign push  = accept;
    assign wdata = data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

endmodule

### rtl/core/dq_fifo.sv
// ----------------------------------------------------------------------------
// dq_fifo
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_fifo
    import dq_pkg::*;
#(
    parameter int ADDR_W = $clog2(DQ_DEPTH)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  op_ctrl_t                 in_ctrl,
    input  logic [ADDR_W-1:0]        in_addr,
    input  logic signed [DATA_W-1:0] in_data,
    input  logic                     pop,
    output logic                     full,
    output logic                     not_empty,
    output op_ctrl_t                 out_ctrl,
    output logic [ADDR_W-1:0]        out_addr,
    output logic signed [DATA_W-1:0] out_data
);

    op_ctrl_t                 ctrl_q [2];
    logic [ADDR_W-1:0]        addr_q [2];
    logic signed [DATA_W-1:0] data_q [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    assign out_ctrl = ctrl_q[rd_ptr_reg];
    assign out_addr = addr_q[rd_ptr_reg];
    assign out_data = data_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_q[wr_ptr_reg] <= in_ctrl;
            addr_q[wr_ptr_reg] <= in_addr;
            data_q[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/core/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back
// Carries out classified items on the slot memory and drives the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_back
    import dq_pkg::*;
#(
    parameter int DEPTH  = DQ_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  op_ctrl_t                 ctrl,
    input  logic [ADDR_W-1:0]        addr,
    input  logic signed [DATA_W-1:0] wdata,
    output logic                     pop,
    output logic                     done,
    output logic signed [DATA_W-1:0] value,
    output logic [1:0]               status,
    output logic                     is_empty,
    output logic                     is_full
);

    logic signed [DATA_W-1:0] slots [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     done_reg;
    op_ctrl_t                 ctrl_reg;

    // the back part never stalls: one item taken every cycle there is one
    assign pop = item_valid;

    always_ff @(posedge clk)
    begin
        if (item_valid && ctrl.kind == OP_WRITE)
        begin
            slots[addr] <= wdata;
        end
        rd_data_reg <= slots[addr];
        ctrl_reg    <= ctrl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid;
        end
    end

    assign done     = done_reg;
    assign value    = (ctrl_reg.kind == OP_READ) ? rd_data_reg : '1;
    assign status   = ctrl_reg.status;
    assign is_empty = ctrl_reg.is_empty;
    assign is_full  = ctrl_reg.is_full;

endmodule

### rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue over a linear array of DEPTH 32-bit slots.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken on a rising edge where start is high and busy is low.
//   cmd selects push back, push front, pop front or pop back; data is the
//   value pushed. Every command gives exactly one result item, shown on
//   value/status/is_empty/is_full for one cycle with done high.
//   Path: the command is classified against the end pointers and pushed
//   into the two-entry queue as it is accepted; the back part then does
//   the slot memory access with its registered read port and raises done.
//   Throughput: one command per cycle; the back part drains the two-entry
//   queue every cycle, so busy only rises if that queue were full.
//   Failed commands leave all state unchanged and give value -1.
//   Reset clears both end pointers (queue empty) and the queue; slot
//   contents are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               cmd,
    input  logic signed [DATA_W-1:0] data,
    output logic                     done,
    output logic signed [DATA_W-1:0] value,
    output logic [1:0]               status,
    output logic                     is_empty,
    output logic                     is_full
);

    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic                     accept;
    logic                     f_push;
    op_ctrl_t                 f_ctrl;
    logic [ADDR_W-1:0]        f_addr;
    logic signed [DATA_W-1:0] f_data;

    logic                     q_full;
    logic                     q_valid;
    op_ctrl_t                 q_ctrl;
    logic [ADDR_W-1:0]        q_addr;
    logic signed [DATA_W-1:0] q_data;
    logic                     b_pop;

    assign busy   = q_full;
    assign accept = start && !q_full;

    dq_front #(
        .DEPTH  (DEPTH),
        .PTR_W  (PTR_W),
        .ADDR_W (ADDR_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .data   (data),
        .push   (f_push),
        .ctrl   (f_ctrl),
        .addr   (f_addr),
        .wdata  (f_data)
    );

    dq_fifo #(
        .ADDR_W (ADDR_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .in_ctrl   (f_ctrl),
        .in_addr   (f_addr),
        .in_data   (f_data),
        .pop       (b_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .out_ctrl  (q_ctrl),
        .out_addr  (q_addr),
        .out_data  (q_data)
    );

    dq_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .ctrl       (q_ctrl),
        .addr       (q_addr),
        .wdata      (q_data),
        .pop        (b_pop),
        .done       (done),
        .value      (value),
        .status     (status),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

endmodule

### rtl/core/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_checker
    import dq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     done,
    input  logic signed [DATA_W-1:0] value,
    input  logic [1:0]               status,
    input  logic                     is_empty
);

    // every accepted item gives its result once it has passed the queue and the back part's registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted item gave no result");

    // no result appears without an item behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_DONE) |-> (value == '1))
        else $error("failed command did not return -1");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> is_empty)
        else $error("empty pop reported a non-empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .value    (value),
    .status   (status),
    .is_empty (is_empty)
);
